// File: hw/rtl/rwphc_pkg.sv
// ----------------------------------------------------------------------------
// rwphc_pkg
// Shared constants, register indexes and state encoding for the rolling
// window peak height compression block.
// ----------------------------------------------------------------------------
package rwphc_pkg;

  // Ring size; must be a power of two so slot pointers wrap naturally.
  localparam int SLOTS   = 8;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int WIN_W   = 20;
  localparam int PROD_W  = 30;                 // window_ms * 1000
  localparam int DUR_W   = PROD_W - SLOT_W;    // slot duration in us
  localparam int EL_W    = DUR_W + 1;          // elapsed time in slot

  localparam int DT_W    = 20;
  localparam int H_W     = 16;
  localparam int UP_W    = 18;
  localparam int Q16_W   = 17;
  localparam int EFF_W   = 22;
  localparam int STAND_W = 33;
  localparam int DIV_W   = 17;                 // quotient bits below overflow

  localparam logic [DUR_W-1:0]   MIN_SLOT_US   = DUR_W'(50000);
  localparam logic [Q16_W-1:0]   ONE_Q16       = Q16_W'(65536);
  localparam logic [Q16_W-1:0]   HIP_FLOOR     = Q16_W'(3277);
  localparam logic [Q16_W-1:0]   CONF_FLOOR    = Q16_W'(16384);
  localparam logic [STAND_W-1:0] STAND_MIN     = STAND_W'(64'd1048576);

  localparam logic [WIN_W-1:0]   WINDOW_RST    = WIN_W'(4000);
  localparam logic [15:0]        LEAN_RST      = 16'd0;
  localparam logic [Q16_W-1:0]   HIP_RST       = Q16_W'(32768);
  localparam logic [Q16_W-1:0]   MIN_ALPHA_RST = Q16_W'(0);

  typedef enum logic [1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_LEAN      = 2'd1,
    CFG_HIP       = 2'd2,
    CFG_MIN_ALPHA = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NP_RD,
    S_NP_OUT,
    S_FIRST,
    S_ADD,
    S_ADV,
    S_RD,
    S_RMW,
    S_SCAN,
    S_SCAN_END,
    S_MUL1,
    S_MUL2,
    S_LEAN,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/rolling_window_peak_height_compression.sv
// ----------------------------------------------------------------------------
// rolling_window_peak_height_compression
// Time-slotted sliding window maximum of head height with pelvis compression
// estimate. Slot peaks live in a small synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | content
//  in_     | in  | in_tvalid/in_tready  | tuser: pose_present; tdata: sample
//  out_    | out | out_tvalid/out_tready| tuser: result_valid; tdata: result
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One beat at a time. A later pose makes up to 21 slot advances for one delta,
// but up to about 2650 right after the window is shortened. The divider runs
// only for a valid result without overflow. rst_n is synchronous; no RAM
// clearing pass. A finished result waits in the output register while the
// next beat is accepted.
// ----------------------------------------------------------------------------
module rolling_window_peak_height_compression
  import rwphc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // head_height[15:0], delta_time_us[35:16],
                                  // torso_upright[53:36], zero pad
  input  logic        in_tuser,   // pose_present
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // baseline_height[15:0], compression_alpha[32:16],
                                  // confidence[49:33], head_drop[65:50],
                                  // lean_compensation[81:66], zero pad
  output logic        out_tuser,  // result_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  // config
  logic [WIN_W-1:0] window_r;
  logic [15:0]      lean_coef_r;
  logic [Q16_W-1:0] hip_r;
  logic [Q16_W-1:0] min_alpha_r;

  // control state
  state_t            state_r, state_nxt;
  logic              present_r, present_nxt;
  logic [SLOT_W-1:0] active_r, active_nxt;
  logic [EL_W-1:0]   elapsed_r, elapsed_nxt;
  logic [SLOTS-1:0]  filled_r, filled_nxt;
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [SLOT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [4:0]        div_cnt_r, div_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // work registers
  logic signed [H_W-1:0]    h_r, h_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic signed [UP_W-1:0]   up_r, up_nxt;
  logic [DUR_W-1:0]         dur_r, dur_nxt;
  logic signed [H_W-1:0]    base_r, base_nxt;
  logic [31:0]              p1_r, p1_nxt;
  logic [48:0]              p2_r, p2_nxt;
  logic [STAND_W-1:0]       stand_r, stand_nxt;
  logic [15:0]              drop_r, drop_nxt;
  logic [15:0]              lean_r, lean_nxt;
  logic [STAND_W-1:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]         q_r, q_nxt;
  logic                     valid_r, valid_nxt;
  logic                     ovf_r, ovf_nxt;

  // result holding
  logic                     res_valid_r, res_valid_nxt;
  logic [15:0]              res_base_r, res_base_nxt;
  logic [Q16_W-1:0]         res_alpha_r, res_alpha_nxt;
  logic [Q16_W-1:0]         res_conf_r, res_conf_nxt;
  logic [15:0]              res_drop_r, res_drop_nxt;
  logic [15:0]              res_lean_r, res_lean_nxt;

  logic [87:0]              out_data_r, out_data_nxt;
  logic                     out_user_r, out_user_nxt;

  // slot peak RAM
  logic signed [H_W-1:0] peak_mem [SLOTS];
  logic signed [H_W-1:0] rd_data_r;
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     mem_waddr, mem_raddr;

  logic [CNT_W-1:0]      fill_cnt;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RST;
      lean_coef_r <= LEAN_RST;
      hip_r       <= HIP_RST;
      min_alpha_r <= MIN_ALPHA_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW:    window_r    <= cfg_data;
        CFG_LEAN:      lean_coef_r <= cfg_data[15:0];
        CFG_HIP:       hip_r       <= cfg_data[Q16_W-1:0];
        CFG_MIN_ALPHA: min_alpha_r <= cfg_data[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      peak_mem[mem_waddr] <= h_r;
    end
    if (mem_re) begin
      rd_data_r <= peak_mem[mem_raddr];
    end
  end

  always_comb begin
    fill_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fill_cnt = fill_cnt + CNT_W'(filled_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= 1'b0;
      active_r    <= '0;
      elapsed_r   <= '0;
      filled_r    <= '0;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      cmp_idx_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      active_r    <= active_nxt;
      elapsed_r   <= elapsed_nxt;
      filled_r    <= filled_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    dt_r        <= dt_nxt;
    up_r        <= up_nxt;
    dur_r       <= dur_nxt;
    base_r      <= base_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    stand_r     <= stand_nxt;
    drop_r      <= drop_nxt;
    lean_r      <= lean_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    valid_r     <= valid_nxt;
    ovf_r       <= ovf_nxt;
    res_valid_r <= res_valid_nxt;
    res_base_r  <= res_base_nxt;
    res_alpha_r <= res_alpha_nxt;
    res_conf_r  <= res_conf_nxt;
    res_drop_r  <= res_drop_nxt;
    res_lean_r  <= res_lean_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  always_comb begin
    logic [PROD_W-1:0]      win_prod;
    logic [DUR_W-1:0]       dur_raw;
    logic [SLOT_W-1:0]      next_slot;
    logic [H_W:0]           drop_w;
    logic [15:0]            base_abs;
    logic [15:0]            base_clamp;
    logic [Q16_W-1:0]       ratio;
    logic [Q16_W-1:0]       up_c;
    logic [Q16_W-1:0]       tilt;
    logic [20:0]            lmag;
    logic [15:0]            lean_pos;
    logic [EFF_W-1:0]       eff;
    logic [STAND_W:0]       rem2;
    logic [Q16_W-1:0]       amin;
    logic [Q16_W-1:0]       alpha_d;
    logic [CNT_W+12:0]      conf_raw;

    state_nxt     = state_r;
    present_nxt   = present_r;
    active_nxt    = active_r;
    elapsed_nxt   = elapsed_r;
    filled_nxt    = filled_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;

    h_nxt         = h_r;
    dt_nxt        = dt_r;
    up_nxt        = up_r;
    dur_nxt       = dur_r;
    base_nxt      = base_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    stand_nxt     = stand_r;
    drop_nxt      = drop_r;
    lean_nxt      = lean_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    valid_nxt     = valid_r;
    ovf_nxt       = ovf_r;
    res_valid_nxt = res_valid_r;
    res_base_nxt  = res_base_r;
    res_alpha_nxt = res_alpha_r;
    res_conf_nxt  = res_conf_r;
    res_drop_nxt  = res_drop_r;
    res_lean_nxt  = res_lean_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    mem_we    = 1'b0;
    mem_waddr = active_r;
    mem_re    = 1'b0;
    mem_raddr = active_r;

    win_prod   = PROD_W'(window_r) * PROD_W'(1000);
    dur_raw    = win_prod[PROD_W-1:SLOT_W];
    next_slot  = active_r + SLOT_W'(1);
    drop_w     = {base_r[H_W-1], base_r} - {h_r[H_W-1], h_r};
    base_abs   = base_r[H_W-1] ? 16'(~base_r + 16'sd1) : 16'(base_r);
    base_clamp = (base_r < 16'sd16) ? 16'd16 : 16'(base_r);
    ratio      = (hip_r < HIP_FLOOR) ? HIP_FLOOR : hip_r;
    if (up_r < 18'sd0) begin
      up_c = '0;
    end else if (up_r > 18'sd65536) begin
      up_c = ONE_Q16;
    end else begin
      up_c = up_r[Q16_W-1:0];
    end
    tilt     = ONE_Q16 - up_c;
    lmag     = p2_r[48:28];
    lean_pos = (lmag > 21'(drop_r)) ? drop_r : lmag[15:0];
    if (base_r[H_W-1]) begin
      eff = EFF_W'(drop_r) + EFF_W'(lmag);
    end else begin
      eff = EFF_W'(drop_r - lean_pos);
    end
    rem2     = {rem_r, 1'b0};
    amin     = (min_alpha_r > ONE_Q16) ? ONE_Q16 : min_alpha_r;
    alpha_d  = ONE_Q16 - q_r;
    conf_raw = {fill_cnt, 13'd0};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmp_v_r && filled_r[cmp_idx_r] && (rd_data_r > base_r)) begin
      base_nxt = rd_data_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          h_nxt    = in_tdata[15:0];
          dt_nxt   = in_tdata[35:16];
          up_nxt   = in_tdata[53:36];
          dur_nxt  = (dur_raw < MIN_SLOT_US) ? MIN_SLOT_US : dur_raw;
          if (!in_tuser) begin
            state_nxt = present_r ? S_NP_RD : S_NP_OUT;
          end else if (!present_r) begin
            state_nxt = S_FIRST;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_NP_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_NP_OUT;
      end
      S_NP_OUT: begin
        res_valid_nxt = 1'b0;
        res_base_nxt  = present_r ? 16'(rd_data_r) : 16'd0;
        res_alpha_nxt = ONE_Q16;
        res_conf_nxt  = '0;
        res_drop_nxt  = '0;
        res_lean_nxt  = '0;
        state_nxt     = S_DONE;
      end
      S_FIRST: begin
        mem_we       = 1'b1;
        mem_waddr    = '0;
        active_nxt   = '0;
        elapsed_nxt  = '0;
        filled_nxt   = SLOTS'(1);
        present_nxt  = 1'b1;
        base_nxt     = h_r;
        scan_idx_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_ADD: begin
        elapsed_nxt = elapsed_r + EL_W'(dt_r);
        state_nxt   = S_ADV;
      end
      S_ADV: begin
        if (elapsed_r >= EL_W'(dur_r)) begin
          elapsed_nxt           = elapsed_r - EL_W'(dur_r);
          active_nxt            = next_slot;
          mem_we                = 1'b1;
          mem_waddr             = next_slot;
          filled_nxt[next_slot] = 1'b1;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_RMW;
      end
      S_RMW: begin
        if (!filled_r[active_r] || (h_r > rd_data_r)) begin
          mem_we = 1'b1;
        end
        filled_nxt[active_r] = 1'b1;
        base_nxt     = h_r;
        scan_idx_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        mem_re       = 1'b1;
        mem_raddr    = scan_idx_r;
        cmp_v_nxt    = 1'b1;
        cmp_idx_nxt  = scan_idx_r;
        scan_idx_nxt = scan_idx_r + SLOT_W'(1);
        if (scan_idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p1_nxt    = 32'(lean_coef_r) * 32'(base_abs);
        drop_nxt  = drop_w[15:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        p2_nxt    = 49'(p1_r) * 49'(tilt);
        stand_nxt = STAND_W'(ratio) * STAND_W'(base_clamp);
        state_nxt = S_LEAN;
      end
      S_LEAN: begin
        lean_nxt    = base_r[H_W-1] ? 16'd0 : lean_pos;
        valid_nxt   = (stand_r > STAND_MIN);
        ovf_nxt     = ({eff, 15'd0} >= (EFF_W + 15)'(stand_r));
        rem_nxt     = STAND_W'({eff, 15'd0});
        q_nxt       = '0;
        div_cnt_nxt = '0;
        if ((stand_r > STAND_MIN) && !({eff, 15'd0} >= (EFF_W + 15)'(stand_r))) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (rem2 >= {1'b0, stand_r}) begin
          rem_nxt = STAND_W'(rem2 - {1'b0, stand_r});
          q_nxt   = {q_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[STAND_W-1:0];
          q_nxt   = {q_r[DIV_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'(DIV_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_valid_nxt = valid_r;
        res_base_nxt  = 16'(base_r);
        res_drop_nxt  = drop_r;
        res_lean_nxt  = lean_r;
        if (!valid_r) begin
          res_alpha_nxt = ONE_Q16;
          res_conf_nxt  = '0;
        end else begin
          if (ovf_r || (q_r > ONE_Q16) || (alpha_d < amin)) begin
            res_alpha_nxt = amin;
          end else begin
            res_alpha_nxt = alpha_d;
          end
          if (conf_raw < (CNT_W + 13)'(CONF_FLOOR)) begin
            res_conf_nxt = CONF_FLOOR;
          end else if (conf_raw > (CNT_W + 13)'(ONE_Q16)) begin
            res_conf_nxt = ONE_Q16;
          end else begin
            res_conf_nxt = Q16_W'(conf_raw);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_valid_r;
          out_data_nxt  = {6'd0, res_lean_r, res_drop_r, res_conf_r,
                           res_alpha_r, res_base_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: dv/rolling_window_peak_height_compression_test.sv
// ----------------------------------------------------------------------------
// rolling_window_peak_height_compression_test
// Self-checking bench for the rolling window peak height block. A behavioral
// predictor tracks the slot ring and works out each result beat; a monitor
// compares every output beat field by field. Directed cases cover reset,
// first pose, slot advance, saturation and register extremes, followed by
// random posture traffic under several register settings and random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rolling_window_peak_height_compression_test
  import rwphc_pkg::*;
();

  localparam longint UNITY         = 65536;
  localparam longint SLOT_FLOOR_US = 50000;
  localparam longint RATIO_FLOOR   = 3277;
  localparam longint CONF_STEP     = 8192;
  localparam longint CONF_MIN      = 16384;
  localparam int     STALL_LIMIT   = 20000;
  localparam int     SETTLE_CYCLES = 80;
  localparam int     HOLD_CYCLES   = 300;

  typedef struct {
    logic        valid;
    logic [15:0] baseline;
    logic [16:0] alpha;
    logic [16:0] conf;
    logic [15:0] drop;
    logic [15:0] lean;
  } posture_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // head_height, delta_time_us, torso_upright, pad
  logic        in_tuser;   // pose_present
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // baseline, alpha, confidence, head_drop, lean, pad
  logic        out_tuser;  // result_valid
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  // predictor state and register shadow
  bit     have_baseline;
  int     cur_slot;
  longint slot_time_us;
  int     slot_max [SLOTS];
  bit     slot_used [SLOTS];
  longint win_ms;
  longint lean_gain;
  longint hip_q16;
  longint alpha_floor;

  posture_t postures_expected [$];

  bit in_idle_on;
  bit out_idle_on;
  int hold_cycles;
  int idle_cycles;
  int n_samples;
  int n_results;
  int n_settings;
  int n_mismatch;

  rolling_window_peak_height_compression i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic posture_t compute_compression(bit pose, logic signed [15:0] h,
                                                   logic [19:0] dt,
                                                   logic signed [17:0] up);
    posture_t r;
    longint   height, base, drop, tilt, mag, lean, eff, ratio, stand;
    longint   alpha, conf, q, floor_a, slot_us;
    int       filled;
    height = h;
    r.valid = 1'b0;
    r.alpha = 17'(UNITY);
    r.conf  = '0;
    r.drop  = '0;
    r.lean  = '0;
    if (!pose) begin
      r.baseline = have_baseline ? 16'(slot_max[cur_slot]) : 16'd0;
      return r;
    end

    slot_us = win_ms * 1000 / SLOTS;
    if (slot_us < SLOT_FLOOR_US) slot_us = SLOT_FLOOR_US;

    if (!have_baseline) begin
      // first pose: delta ignored, ring restarts at slot 0
      cur_slot = 0;
      slot_time_us = 0;
      slot_max[0] = int'(height);
      slot_used[0] = 1'b1;
      have_baseline = 1'b1;
    end else begin
      slot_time_us = slot_time_us + longint'(dt);
      while (slot_time_us >= slot_us) begin
        slot_time_us = slot_time_us - slot_us;
        cur_slot = (cur_slot + 1) % SLOTS;
        slot_max[cur_slot] = int'(height);
        slot_used[cur_slot] = 1'b1;
      end
      if (height > slot_max[cur_slot]) slot_max[cur_slot] = int'(height);
      slot_used[cur_slot] = 1'b1;
    end

    base = height;
    filled = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (slot_max[i] > base) base = slot_max[i];
        filled++;
      end
    end

    drop = base - height;
    if (drop < 0) drop = 0;

    tilt = up;
    if (tilt < 0) tilt = 0;
    if (tilt > UNITY) tilt = UNITY;
    tilt = UNITY - tilt;

    mag = lean_gain * (base < 0 ? -base : base) * tilt;
    lean = mag / (longint'(1) << 28);
    if (base < 0) lean = -lean;
    if (lean > drop) lean = drop;
    eff = drop - lean;
    if (eff < 0) eff = 0;

    ratio = (hip_q16 < RATIO_FLOOR) ? RATIO_FLOOR : hip_q16;
    stand = ratio * ((base < 16) ? longint'(16) : base);
    r.valid = stand > 16 * UNITY;

    alpha = UNITY;
    conf = 0;
    if (r.valid) begin
      q = (eff << 32) / stand;
      floor_a = (alpha_floor > UNITY) ? UNITY : alpha_floor;
      alpha = UNITY - q;
      if (alpha < floor_a) alpha = floor_a;
      if (alpha > UNITY) alpha = UNITY;
      conf = filled * CONF_STEP;
      if (conf < CONF_MIN) conf = CONF_MIN;
      if (conf > UNITY) conf = UNITY;
    end

    if (lean < 0) lean = 0;
    if (lean > 65535) lean = 65535;
    if (drop > 65535) drop = 65535;

    r.baseline = 16'(base);
    r.alpha    = 17'(alpha);
    r.conf     = 17'(conf);
    r.drop     = 16'(drop);
    r.lean     = 16'(lean);
    return r;
  endfunction

  task automatic send_sample(bit pose, int h, int dt, int up);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= pose;
    in_tdata  <= {2'b00, up[17:0], dt[19:0], h[15:0]};
    do @(posedge clk); while (!in_tready);
    postures_expected.push_back(compute_compression(pose, h[15:0], dt[19:0], up[17:0]));
    n_samples++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (postures_expected.size() != 0) @(posedge clk);
  endtask

  // block must be idle; writes all four registers back to back
  task automatic load_registers(int unsigned win, int unsigned gain, int unsigned hip,
                                int unsigned amin);
    cfg_idx_t    order [4] = '{CFG_WINDOW, CFG_LEAN, CFG_HIP, CFG_MIN_ALPHA};
    logic [19:0] vals [4];
    vals = '{win[19:0], gain[19:0], hip[19:0], amin[19:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (order[i])
        CFG_WINDOW:    win_ms      = vals[i];
        CFG_LEAN:      lean_gain   = vals[i][15:0];
        CFG_HIP:       hip_q16     = vals[i][16:0];
        CFG_MIN_ALPHA: alpha_floor = vals[i][16:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic send_random_sample();
    int  h, dt, up, pick;
    bit  pose;
    pose = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 55)      h = $urandom_range(2400, 2900);
    else if (pick < 70) h = $urandom_range(1200, 2400);
    else if (pick < 85) h = int'($urandom_range(0, 65535)) - 32768;
    else                h = int'($urandom_range(0, 128)) - 64;
    pick = $urandom_range(0, 99);
    if (pick < 70)      dt = $urandom_range(5000, 15000);
    else if (pick < 90) dt = $urandom_range(0, 200000);
    else                dt = $urandom_range(0, 1000000);
    pick = $urandom_range(0, 99);
    if (pick < 60)      up = $urandom_range(50000, 65536);
    else if (pick < 80) up = int'($urandom_range(0, 131072)) - 65536;
    else                up = $urandom_range(0, 65536);
    send_sample(pose, h, dt, up);
  endtask

  task automatic test_directed_cases();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_sample(1'b0, 1234, 500, 65536);       // no pose before any baseline
    send_sample(1'b1, 2720, 1000000, 65536);   // first pose, delta ignored
    send_sample(1'b0, -5, 7, 0);               // no pose reports active slot peak
    send_sample(1'b1, 2600, 0, 0);
    send_sample(1'b1, 2800, 500000, -65536);   // exactly one slot advance
    send_sample(1'b1, 1500, 1000000, 32768);
    send_sample(1'b1, 32767, 11111, 65536);
    send_sample(1'b1, -32768, 11111, 0);       // drop saturates
    send_sample(1'b1, 10, 0, 131071 - 65536);
    wait_for_results();
    load_registers(400, 65535, 0, 65536);      // floored hip, alpha pinned at one
    send_sample(1'b1, -32768, 1000000, -65536); // ring overwritten, negative base
    send_sample(1'b1, 16, 50000, 0);
    send_sample(1'b1, 20, 49999, 1);
    send_sample(1'b0, 0, 0, 0);
    wait_for_results();
    load_registers(600000, 4096, 65536, 0);
    send_sample(1'b1, 2720, 1000000, 40000);
    send_sample(1'b1, 1000, 0, 20000);
    send_sample(1'b1, 2000, 1000, -1);
    send_sample(1'b0, 2000, 0, 0);
    wait_for_results();
    load_registers(800, 65535, 3276, 65535);
    send_sample(1'b1, 2720, 100000, 0);
    send_sample(1'b1, 100, 99999, 0);
    send_sample(1'b1, 2200, 1, 65536);
    send_sample(1'b1, 0, 0, 65535);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    load_registers(0, 0, 3277, 0);
    repeat (10) send_random_sample();
    wait_for_results();
    load_registers(1048575, 65535, 65536, 65536);
    repeat (10) send_random_sample();
    wait_for_results();
  endtask

  // receiver holds off so the block backs up into the input side
  task automatic test_output_backpressure();
    wait_for_results();
    in_idle_on  = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (16) send_random_sample();
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int unsigned win, gain, hip, amin;
    int          pick;
    for (int phase = 0; phase < 5; phase++) begin
      wait_for_results();
      pick = $urandom_range(0, 3);
      if (pick < 2)       win = $urandom_range(0, 3200);
      else if (pick == 2) win = $urandom_range(3200, 40000);
      else                win = $urandom_range(40000, 600000);
      pick = $urandom_range(0, 3);
      if (pick == 0)      gain = 0;
      else if (pick == 1) gain = $urandom_range(2048, 8192);
      else                gain = $urandom_range(0, 65535);
      hip  = $urandom_range(0, 65536);
      pick = $urandom_range(0, 3);
      if (pick == 0)      amin = $urandom_range(0, 65536);
      else                amin = 0;
      load_registers(win, gain, hip, amin);
      for (int n = 0; n < 90; n++) begin
        if (n % 20 == 0) begin
          in_idle_on  = $urandom_range(0, 2) != 0;
          out_idle_on = $urandom_range(0, 2) != 0;
        end
        send_random_sample();
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_WINDOW;
    cfg_data    <= '0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_cycles = 0;
    n_samples   = 0;
    n_results   = 0;
    n_settings  = 0;
    n_mismatch  = 0;
    have_baseline = 1'b0;
    cur_slot      = 0;
    slot_time_us  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_max[i]  = 0;
      slot_used[i] = 1'b0;
    end
    win_ms      = 4000;
    lean_gain   = 0;
    hip_q16     = 32768;
    alpha_floor = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d result beats over %0d register settings,",
             n_samples, n_results, n_settings);
    $display("including no-pose ticks, slot wrap, output hold-off; %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result receiver
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 15) : 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    posture_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (postures_expected.size() == 0) begin
        $error("result beat with nothing outstanding");
        n_mismatch++;
      end else begin
        want = postures_expected.pop_front();
        check_field("result_valid", 17'(want.valid), 17'(out_tuser));
        check_field("baseline_height", 17'(want.baseline), 17'(out_tdata[15:0]));
        check_field("compression_alpha", want.alpha, out_tdata[32:16]);
        check_field("confidence", want.conf, out_tdata[49:33]);
        check_field("head_drop", 17'(want.drop), 17'(out_tdata[65:50]));
        check_field("lean_compensation", 17'(want.lean), 17'(out_tdata[81:66]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no beat accepted for %0d cycles, %0d results outstanding",
               idle_cycles, postures_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
hw/rtl/rwphc_pkg.sv
hw/rtl/rolling_window_peak_height_compression.sv
dv/rolling_window_peak_height_compression_test.sv
